// File: rtl/core/uodc_pkg.sv
// uodc_pkg: item types, calendar constants and month tables
// used by utc_offset_date_convert and uodc_civil; no dependencies
package uodc_pkg;

    typedef struct packed {
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [4:0]  in_hour;
        logic [5:0]  in_minute;
    } t_in;

    typedef struct packed {
        logic        valid_res;
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
    } t_out;

    localparam logic [13:0] MAX_YEAR    = 14'd9999;
    localparam logic [10:0] MIN_PER_DAY = 11'd1440;
    localparam logic [17:0] DAYS_400Y   = 18'd146097;
    localparam logic [15:0] DAYS_100Y   = 16'd36524;
    localparam logic [10:0] DAYS_4Y     = 11'd1461;
    localparam logic [8:0]  DAYS_1Y     = 9'd365;
    // first minute past the last day of the last year
    localparam logic [34:0] TOT_LIMIT   = 35'd5258964960;
    // reciprocal multipliers
    localparam logic [12:0] RCP_100     = 13'd5243;     // ceil(2^19/100)
    localparam logic [28:0] RCP_45      = 29'd381774870; // floor(2^34/45)
    localparam logic [17:0] RCP_400Y    = 18'd235184;   // floor(2^35/146097)
    localparam logic [18:0] RCP_4Y      = 19'd367468;   // floor(2^29/1461)
    localparam logic [11:0] RCP_60      = 12'd2185;     // ceil(2^17/60)

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
            4'd2:                                        d = leap ? 5'd29 : 5'd28;
            default:                                     d = 5'd0;
        endcase
        return d;
    endfunction

    // days of the year before the first of month m
    function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
        logic [8:0] c;
        case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        if (leap && m > 4'd2) begin
            c = c + 9'd1;
        end
        return c;
    endfunction

endpackage

// File: rtl/core/utc_offset_date_convert.sv
// utc_offset_date_convert: date and time shift by a signed minute offset
// pipelined from acceptance to result; accepts one item per cycle while the result is not stalled
// the whole pipeline holds while the result is stalled
// synchronous active-low reset clears valid bits and the offset register to 0
// depends on uodc_pkg and uodc_civil
module utc_offset_date_convert
    import uodc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    logic        w_en;
    logic [11:0] r_vld;
    logic [31:0] r_offset;

    assign w_en    = !(r_vld[11] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[11];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_offset <= '0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[10:0], i_valid};
            end
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
        end
    end

    // stage 1: capture, century quotients
    t_in        r1_in;
    logic [7:0] r1_yq;
    logic [7:0] r1_pq;
    logic [13:0] w1_p;
    logic [26:0] w1_yprod;
    logic [26:0] w1_pprod;

    assign w1_p     = i_data.in_year - 14'd1;
    assign w1_yprod = {13'd0, i_data.in_year} * {14'd0, RCP_100};
    assign w1_pprod = {13'd0, w1_p} * {14'd0, RCP_100};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_in <= i_data;
            r1_yq <= w1_yprod[26:19];
            r1_pq <= w1_pprod[26:19];
        end
    end

    // stage 2: check and day count
    logic        r2_ok;
    logic [21:0] r2_days;
    logic [10:0] r2_hm;
    logic        w2_leap;
    logic        w2_ok;
    logic [13:0] w2_p;

    assign w2_p    = r1_in.in_year - 14'd1;
    assign w2_leap = (r1_in.in_year[1:0] == 2'b00)
                  && ((r1_in.in_year != 14'(r1_yq * 7'd100)) || (r1_yq[1:0] == 2'b00));
    assign w2_ok   = (r1_in.in_year >= 14'd1) && (r1_in.in_year <= MAX_YEAR)
                  && (r1_in.in_month >= 4'd1) && (r1_in.in_month <= 4'd12)
                  && (r1_in.in_day >= 5'd1)
                  && (r1_in.in_day <= month_len(r1_in.in_month, w2_leap))
                  && (r1_in.in_hour <= 5'd23) && (r1_in.in_minute <= 6'd59);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ok   <= w2_ok;
            r2_days <= 22'(w2_p * 9'd365) + 22'(w2_p[13:2]) - 22'(r1_pq) + 22'(r1_pq[7:2])
                     + 22'(cum_days(r1_in.in_month, w2_leap)) + 22'(r1_in.in_day) - 22'd1;
            r2_hm   <= 11'(r1_in.in_hour * 6'd60) + 11'(r1_in.in_minute);
        end
    end

    // stage 3: minute count plus offset
    logic               r3_ok;
    logic signed [35:0] r3_tot;
    logic [32:0]        w3_dm;

    assign w3_dm = {11'd0, r2_days} * {22'd0, MIN_PER_DAY};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_ok  <= r2_ok;
            r3_tot <= $signed({3'b000, w3_dm}) + $signed({25'd0, r2_hm})
                    + $signed({{4{r_offset[31]}}, r_offset});
        end
    end

    // stage 4: range check, day quotient estimate
    logic        r4_ok;
    logic [21:0] r4_q;
    logic [32:0] r4_tot;
    logic [56:0] w4_p;

    assign w4_p = {29'd0, r3_tot[32:5]} * {28'd0, RCP_45};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ok  <= r3_ok && !r3_tot[35] && (r3_tot[34:0] < TOT_LIMIT);
            r4_q   <= w4_p[55:34];
            r4_tot <= r3_tot[32:0];
        end
    end

    // stage 5: day count and minute of day
    logic        r5_ok;
    logic [21:0] r5_dd;
    logic [10:0] r5_mod;
    logic [32:0] w5_rem;

    assign w5_rem = r4_tot - ({11'd0, r4_q} * {22'd0, MIN_PER_DAY});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_ok <= r4_ok;
            if (w5_rem[11:0] >= 12'(MIN_PER_DAY)) begin
                r5_dd  <= r4_q + 22'd1;
                r5_mod <= 11'(w5_rem[11:0] - 12'(MIN_PER_DAY));
            end else begin
                r5_dd  <= r4_q;
                r5_mod <= w5_rem[10:0];
            end
        end
    end

    uodc_civil u_civil (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ok  (r5_ok),
        .i_dd  (r5_dd),
        .i_mod (r5_mod),
        .o_res (o_data)
    );

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.valid_res) |-> (o_data.out_year == 14'd0
            && o_data.out_month == 4'd0 && o_data.out_day == 5'd0
            && o_data.out_hour == 5'd0 && o_data.out_minute == 6'd0))
        else $error("invalid result with nonzero fields");

    a_valid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.valid_res) |-> (o_data.out_year >= 14'd1
            && o_data.out_year <= MAX_YEAR && o_data.out_month >= 4'd1
            && o_data.out_month <= 4'd12 && o_data.out_day >= 5'd1
            && o_data.out_hour <= 5'd23 && o_data.out_minute <= 6'd59))
        else $error("valid result out of range");

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result after reset");

endmodule

// File: rtl/core/uodc_civil.sv
// uodc_civil: day count and minute of day back to calendar fields, seven stages
// depends on uodc_pkg
module uodc_civil
    import uodc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic        i_ok,
    input  logic [21:0] i_dd,
    input  logic [10:0] i_mod,
    output t_out        o_res
);

    // stage 6
    logic        r6_ok;
    logic [21:0] r6_dd;
    logic [4:0]  r6_q400;
    logic [4:0]  r6_hr;
    logic [10:0] r6_mod;
    logic [39:0] w6_pq;
    logic [22:0] w6_ph;

    assign w6_pq = {18'd0, i_dd} * {22'd0, RCP_400Y};
    assign w6_ph = {12'd0, i_mod} * {11'd0, RCP_60};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_ok   <= i_ok;
            r6_dd   <= i_dd;
            r6_q400 <= w6_pq[39:35];
            r6_hr   <= w6_ph[21:17];
            r6_mod  <= i_mod;
        end
    end

    // stage 7
    logic        r7_ok;
    logic [4:0]  r7_n400;
    logic [17:0] r7_r;
    logic [4:0]  r7_hr;
    logic [5:0]  r7_mi;
    logic [21:0] w7_rem;
    logic [10:0] w7_mi;

    assign w7_rem = r6_dd - 22'(r6_q400 * DAYS_400Y);
    assign w7_mi  = r6_mod - 11'(r6_hr * 6'd60);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_ok <= r6_ok;
            if (w7_rem >= 22'(DAYS_400Y)) begin
                r7_n400 <= r6_q400 + 5'd1;
                r7_r    <= 18'(w7_rem - 22'(DAYS_400Y));
            end else begin
                r7_n400 <= r6_q400;
                r7_r    <= w7_rem[17:0];
            end
            r7_hr <= r6_hr;
            r7_mi <= w7_mi[5:0];
        end
    end

    // stage 8: century within the 400-year cycle
    logic        r8_ok;
    logic [13:0] r8_yb;
    logic [15:0] r8_r;
    logic [1:0]  r8_n100;
    logic [4:0]  r8_hr;
    logic [5:0]  r8_mi;
    logic [1:0]  w8_n100;

    always_comb begin
        if (r7_r < 18'd36524) begin
            w8_n100 = 2'd0;
        end else if (r7_r < 18'd73048) begin
            w8_n100 = 2'd1;
        end else if (r7_r < 18'd109572) begin
            w8_n100 = 2'd2;
        end else begin
            w8_n100 = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_ok   <= r7_ok;
            r8_n100 <= w8_n100;
            r8_yb   <= 14'(r7_n400 * 9'd400) + 14'(w8_n100 * 7'd100);
            r8_r    <= 16'(r7_r - 18'(w8_n100 * DAYS_100Y));
            r8_hr   <= r7_hr;
            r8_mi   <= r7_mi;
        end
    end

    // stage 9
    logic        r9_ok;
    logic [13:0] r9_yb;
    logic [15:0] r9_r;
    logic [1:0]  r9_n100;
    logic [4:0]  r9_n4;
    logic [4:0]  r9_hr;
    logic [5:0]  r9_mi;
    logic [34:0] w9_p;

    assign w9_p = {19'd0, r8_r} * {16'd0, RCP_4Y};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r9_ok   <= r8_ok;
            r9_yb   <= r8_yb;
            r9_r    <= r8_r;
            r9_n100 <= r8_n100;
            r9_n4   <= w9_p[33:29];
            r9_hr   <= r8_hr;
            r9_mi   <= r8_mi;
        end
    end

    // stage 10
    logic        r10_ok;
    logic [13:0] r10_yb;
    logic [10:0] r10_r;
    logic [1:0]  r10_n100;
    logic [4:0]  r10_n4;
    logic [4:0]  r10_hr;
    logic [5:0]  r10_mi;
    logic [15:0] w10_rem;

    assign w10_rem = r9_r - 16'(r9_n4 * DAYS_4Y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r10_ok   <= r9_ok;
            r10_yb   <= r9_yb;
            r10_n100 <= r9_n100;
            if (w10_rem >= 16'(DAYS_4Y)) begin
                r10_n4 <= r9_n4 + 5'd1;
                r10_r  <= 11'(w10_rem - 16'(DAYS_4Y));
            end else begin
                r10_n4 <= r9_n4;
                r10_r  <= w10_rem[10:0];
            end
            r10_hr <= r9_hr;
            r10_mi <= r9_mi;
        end
    end

    // stage 11: year within the 4-year block
    logic        r11_ok;
    logic [13:0] r11_oy;
    logic [8:0]  r11_r;
    logic        r11_leap;
    logic [4:0]  r11_hr;
    logic [5:0]  r11_mi;
    logic [1:0]  w11_n1;

    always_comb begin
        if (r10_r < 11'd365) begin
            w11_n1 = 2'd0;
        end else if (r10_r < 11'd730) begin
            w11_n1 = 2'd1;
        end else if (r10_r < 11'd1095) begin
            w11_n1 = 2'd2;
        end else begin
            w11_n1 = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r11_ok   <= r10_ok;
            r11_oy   <= r10_yb + 14'({r10_n4, 2'b00}) + 14'(w11_n1) + 14'd1;
            r11_r    <= 9'(r10_r - 11'(w11_n1 * DAYS_1Y));
            r11_leap <= (w11_n1 == 2'd3) && ((r10_n4 != 5'd24) || (r10_n100 == 2'd3));
            r11_hr   <= r10_hr;
            r11_mi   <= r10_mi;
        end
    end

    // stage 12: month and day, result register
    logic [3:0] w12_mo;
    logic [8:0] w12_day;

    always_comb begin
        w12_mo = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (r11_r >= cum_days(4'(k), r11_leap)) begin
                w12_mo = 4'(k);
            end
        end
        w12_day = r11_r - cum_days(w12_mo, r11_leap) + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.valid_res  <= r11_ok;
            o_res.out_year   <= r11_ok ? r11_oy : 14'd0;
            o_res.out_month  <= r11_ok ? w12_mo : 4'd0;
            o_res.out_day    <= r11_ok ? w12_day[4:0] : 5'd0;
            o_res.out_hour   <= r11_ok ? r11_hr : 5'd0;
            o_res.out_minute <= r11_ok ? r11_mi : 6'd0;
        end
    end

endmodule

// File: dv/utc_offset_date_convert_test.sv
// utc_offset_date_convert_test: self-checking bench for the date and time offset shifter
// drives items through valid/stall, predicts each shifted date, checks in order
// depends on uodc_pkg and utc_offset_date_convert
`timescale 1ns / 1ps

module utc_offset_date_convert_test;
    import uodc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int n_accepted;
    int n_valid_out;
    int n_mismatch;
    longint shift_now;

    utc_offset_date_convert dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    function automatic bit yr_is_leap(longint y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_span(longint y, int m);
        int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        int d;
        d = lens[(m - 1) % 12];
        if (m == 2 && yr_is_leap(y)) begin
            d++;
        end
        return d;
    endfunction

    function automatic t_out shifted_date(t_in x, longint shift);
        t_out r;
        longint y, dd, md, rem, p, total, n400, n100, n4, n1, oy;
        int mo, om;
        r = '0;
        y = x.in_year;
        mo = x.in_month;
        if (y < 1 || y > MAX_YEAR || mo < 1 || mo > 12 || x.in_day < 1 ||
            x.in_day > month_span(y, mo) || x.in_hour > 23 || x.in_minute > 59) begin
            return r;
        end
        p = y - 1;
        dd = p * 365 + p / 4 - p / 100 + p / 400;
        for (int m = 1; m < mo; m++) begin
            dd += month_span(y, m);
        end
        dd += x.in_day - 1;
        total = dd * 1440 + x.in_hour * 60 + x.in_minute + shift;
        dd = total / 1440;
        md = total % 1440;
        if (md < 0) begin
            md += 1440;
            dd--;
        end
        if (dd < 0) begin
            return r;
        end
        n400 = dd / 146097;
        rem = dd % 146097;
        n100 = rem / 36524;
        if (n100 > 3) begin
            n100 = 3;
        end
        rem -= n100 * 36524;
        n4 = rem / 1461;
        rem -= n4 * 1461;
        n1 = rem / 365;
        if (n1 > 3) begin
            n1 = 3;
        end
        rem -= n1 * 365;
        oy = n400 * 400 + n100 * 100 + n4 * 4 + n1 + 1;
        if (oy > MAX_YEAR) begin
            return r;
        end
        om = 1;
        while (om < 12 && rem >= month_span(oy, om)) begin
            rem -= month_span(oy, om);
            om++;
        end
        r.valid_res  = 1'b1;
        r.out_year   = oy[13:0];
        r.out_month  = om[3:0];
        r.out_day    = 5'(rem + 1);
        r.out_hour   = 5'(md / 60);
        r.out_minute = 6'(md % 60);
        return r;
    endfunction

    class date_scoreboard;
        t_out pending[$];

        function void note_item(t_in x, longint shift);
            pending.push_back(shifted_date(x, shift));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("unexpected result %h", got);
                end
                return;
            end
            want = pending.pop_front();
            if (got.valid_res !== want.valid_res || got.out_year !== want.out_year ||
                got.out_month !== want.out_month || got.out_day !== want.out_day ||
                got.out_hour !== want.out_hour || got.out_minute !== want.out_minute) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("mismatch: expected v%0d %0d-%0d-%0d %0d:%0d got v%0d %0d-%0d-%0d %0d:%0d",
                        want.valid_res, want.out_year, want.out_month, want.out_day,
                        want.out_hour, want.out_minute, got.valid_res, got.out_year,
                        got.out_month, got.out_day, got.out_hour, got.out_minute);
                end
            end
        endfunction
    endclass

    date_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // accept and check at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_item(i_data, shift_now);
                n_accepted++;
            end
            if (o_valid && !i_stall) begin
                if (o_data.valid_res) begin
                    n_valid_out++;
                end
                sb.check_result(o_data);
            end
        end
    end

    // receiver stall, with a long hold-off when requested
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic send_item(t_in x);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= x;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic drain_and_set(logic [31:0] v);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        shift_now = longint'($signed(v));
    endtask

    function automatic t_in make_date(int y, int m, int d, int h, int mi);
        t_in x;
        x.in_year = 14'(y);
        x.in_month = 4'(m);
        x.in_day = 5'(d);
        x.in_hour = 5'(h);
        x.in_minute = 6'(mi);
        return x;
    endfunction

    function automatic t_in rand_item();
        t_in x;
        int y, m;
        if ($urandom_range(9) == 0) begin
            x = 34'({$urandom(), $urandom()});
        end else begin
            case ($urandom_range(3))
                0: y = $urandom_range(1, 3);
                1: y = $urandom_range(9997, 9999);
                2: y = 400 * $urandom_range(1, 24) + $urandom_range(0, 1) * 100;
                default: y = $urandom_range(1, 9999);
            endcase
            m = $urandom_range(1, 12);
            x = make_date(y, m, $urandom_range(1, month_span(y, m)),
                          $urandom_range(0, 23), $urandom_range(0, 59));
            if ($urandom_range(19) == 0) begin
                x.in_day = 5'(month_span(y, m) + 1);
            end
        end
        return x;
    endfunction

    function automatic logic [31:0] rand_offset();
        case ($urandom_range(4))
            0: return $urandom();
            1: return $urandom_range(0, 2000) - 1000;
            2: return $urandom_range(0, 2880000) - 1440000;
            3: return 32'h8000_0000 + $urandom_range(0, 100);
            default: return 32'h7fff_ffff - $urandom_range(0, 100);
        endcase
    endfunction

    initial begin
        logic [31:0] edge_offsets[6];
        sb = new();
        edge_offsets = '{32'd0, 32'hffff_ffff, 32'd1, 32'h8000_0000, 32'h7fff_ffff, 32'd1440};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 0;
        n_accepted = 0;
        n_valid_out = 0;
        n_mismatch = 0;
        shift_now = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, leap days, bad fields, under every edge offset
        foreach (edge_offsets[k]) begin
            drain_and_set(edge_offsets[k]);
            send_item(make_date(1, 1, 1, 0, 0));
            send_item(make_date(9999, 12, 31, 23, 59));
            send_item(make_date(2000, 2, 29, 12, 30));
            send_item(make_date(1900, 2, 29, 0, 0));
            send_item(make_date(0, 1, 1, 0, 0));
            send_item(make_date(16383, 15, 31, 31, 63));
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 81 : 0;
            recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 33 : 0;
            for (int blk = 0; blk < 6; blk++) begin
                drain_and_set(rand_offset());
                if (ph == 2 && blk == 0) begin
                    hold_cycles = 300;
                end
                repeat (110) send_item(rand_item());
            end
        end

        i_valid <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (30) @(negedge i_clk);
        $display("%0d items shifted across 24 offsets, %0d dates in range", n_accepted,
                 n_valid_out);
        if (n_mismatch == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
